### rtl/rpal_pkg.sv
// Shared types, constants and constant functions of the RMS and peak limiter.
package rpal_pkg;

	localparam int SB       = 24;
	localparam int WIN      = 256;
	localparam int WIN_AW   = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int SQ_W     = 2 * SB;
	localparam int SUM_W    = (2 * SB + WIN_AW > 64) ? 64 : 2 * SB + WIN_AW;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 32;

	localparam logic [CFG_IW-1:0] REG_ENABLES   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_RMS_THR   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_RMS_SLOPE = 3'd2;
	localparam logic [CFG_IW-1:0] REG_RMS_COEF  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_PK_THR    = 3'd4;
	localparam logic [CFG_IW-1:0] REG_PK_SLOPE  = 3'd5;
	localparam logic [CFG_IW-1:0] REG_PK_COEF   = 3'd6;

	localparam logic [16:0] SLOPE_RESET  = 17'd58982;
	localparam logic [16:0] SLOPE_ONE    = 17'd65536;
	localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
	localparam logic [17:0] DB_PER_LOG2  = 18'd197283;
	localparam logic [21:0] LOG2_PER_DB  = 22'd2786640;
	localparam logic signed [15:0] DB_FLOOR = -16'sd32768;

	typedef logic [15:0][30:0] exp_tab_t;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bt;
		rem = v;
		res = '0;
		bt  = 64'd1 << 62;
		while (bt > rem) bt = bt >> 2;
		while (bt != 0) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    tab;
		logic [63:0] cur;
		cur = int_sqrt(64'd1 << 59);
		tab[0] = cur[30:0];
		for (int k = 1; k < 16; k++) begin
			cur = int_sqrt(cur << 30);
			tab[k] = cur[30:0];
		end
		return tab;
	endfunction

	function automatic logic [31:0] log2_q16_const(input logic [63:0] v);
		int          n;
		logic [63:0] x;
		logic [15:0] fr;
		n = 63;
		while (n > 0 && v[n] == 1'b0) n = n - 1;
		x = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
		fr = '0;
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			fr = {fr[14:0], 1'b0};
			if (x >= 64'h8000_0000) begin
				x = x >> 1;
				fr[0] = 1'b1;
			end
		end
		return (32'(n) << 16) + 32'(fr);
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();
	localparam logic [31:0] RMS_OFF = log2_q16_const(64'(WIN)) + (32'(2 * (SB - 1)) << 16);
	localparam logic [31:0] PK_OFF  = 32'(SB - 1) << 16;

	typedef struct packed {
		logic                 vld;
		logic signed [SB-1:0] sample;
	} rpal_req_t;

	typedef struct packed {
		logic take;
		logic clr_done;
	} rpal_ack_t;

	typedef enum logic [15:0] {
		ST_CLR  = 16'b0000_0000_0000_0001,
		ST_IDLE = 16'b0000_0000_0000_0010,
		ST_RSQ  = 16'b0000_0000_0000_0100,
		ST_RSUM = 16'b0000_0000_0000_1000,
		ST_NORM = 16'b0000_0000_0001_0000,
		ST_SQR  = 16'b0000_0000_0010_0000,
		ST_LVL  = 16'b0000_0000_0100_0000,
		ST_DBS  = 16'b0000_0000_1000_0000,
		ST_ENVT = 16'b0000_0001_0000_0000,
		ST_ENVE = 16'b0000_0010_0000_0000,
		ST_GT   = 16'b0000_0100_0000_0000,
		ST_GEXP = 16'b0000_1000_0000_0000,
		ST_GSH  = 16'b0001_0000_0000_0000,
		ST_GMUL = 16'b0010_0000_0000_0000,
		ST_PKS  = 16'b0100_0000_0000_0000,
		ST_OUT  = 16'b1000_0000_0000_0000
	} rpal_state_t;

endpackage

### rtl/rms_and_peak_audio_limiter_unit.sv
// Top level of the RMS and peak audio limiter.
//  channel   direction  handshake       payload
//  input     in         push / full     sample_in
//  result    out        empty / pop     sample_out, total_reduction_db
//  config    in         wr_en           wr_index, wr_data
// One request runs the RMS stage, then the peak stage, each only if enabled; a stage
// with a nonzero level walks the normalize step of the log2 unit, a 16-step squaring
// loop and a 16-step gain product loop.
// After reset a clearing pass zeroes the window; full stays high until it ends.
// A two-entry input queue and the result register let each side stall alone.
module rms_and_peak_audio_limiter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic signed [rpal_pkg::SB-1:0]        sample_in,
	output logic                                  full,
	input  logic                                  pop,
	output logic                                  empty,
	output logic signed [rpal_pkg::SB-1:0]        sample_out,
	output logic [15:0]                           total_reduction_db,
	input  logic                                  wr_en,
	input  logic [rpal_pkg::CFG_IW-1:0]           wr_index,
	input  logic [rpal_pkg::CFG_DW-1:0]           wr_data
);

	rpal_pkg::rpal_req_t req;
	rpal_pkg::rpal_ack_t ack;

	rpal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample_in (sample_in),
		.full      (full),
		.req       (req),
		.ack       (ack)
	);

	rpal_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.req                (req),
		.ack                (ack),
		.pop                (pop),
		.empty              (empty),
		.sample_out         (sample_out),
		.total_reduction_db (total_reduction_db)
	);

endmodule

### rtl/rpal_front.sv
// Input side: two-entry request queue ahead of the processing engine.
module rpal_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic signed [rpal_pkg::SB-1:0] sample_in,
	output logic                          full,
	output rpal_pkg::rpal_req_t           req,
	input  rpal_pkg::rpal_ack_t           ack
);

	logic signed [rpal_pkg::SB-1:0] buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2) || !ack.clr_done;
	assign do_push = push && !full;
	assign do_pop  = ack.take && (cnt_q != 2'd0);

	assign req.vld    = (cnt_q != 2'd0);
	assign req.sample = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) buf_q[wp_q] <= sample_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

### rtl/rpal_back.sv
// Processing engine: window, log2, envelope, gain and result register.
module rpal_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rpal_pkg::CFG_IW-1:0]    wr_index,
	input  logic [rpal_pkg::CFG_DW-1:0]    wr_data,
	input  rpal_pkg::rpal_req_t            req,
	output rpal_pkg::rpal_ack_t            ack,
	input  logic                           pop,
	output logic                           empty,
	output logic signed [rpal_pkg::SB-1:0] sample_out,
	output logic [15:0]                    total_reduction_db
);

	localparam int SB = rpal_pkg::SB;
	localparam int AW = rpal_pkg::WIN_AW;

	rpal_pkg::rpal_state_t st_q;

	logic [1:0]  en_q;
	logic [15:0] rthr_q, pthr_q;
	logic [16:0] rslope_q, pslope_q;
	logic [31:0] rcoef_q, pcoef_q;

	logic [rpal_pkg::SQ_W-1:0] mem [rpal_pkg::WIN];
	logic [rpal_pkg::SQ_W-1:0] rd_q, sq_q;
	logic [rpal_pkg::SUM_W-1:0] sum_q;
	logic [AW-1:0] pos_q, clr_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [rpal_pkg::SQ_W-1:0] mem_wd;

	logic signed [SB-1:0] x_q;
	logic [63:0]          lx_q;
	logic [5:0]           ln_q;
	logic [30:0]          mx_q;
	logic [15:0]          fr_q;
	logic [3:0]           it_q;
	logic                 stg_q;
	logic signed [15:0]   lvl_q;
	logic signed [50:0]   p_q;
	logic [16:0]          tgt_q;
	logic [15:0]          renv_q, penv_q, e_q;
	logic [16:0]          tot_q;
	logic [29:0]          t_q;
	logic [30:0]          g_q;
	logic                 ovld_q;
	logic signed [SB-1:0] osmp_q;
	logic [15:0]          otot_q;

	logic [SB-1:0]              xmag;
	logic [rpal_pkg::SUM_W-1:0] nsum;
	logic [61:0]                sqv;
	logic signed [31:0]         lg, lv;
	logic signed [26:0]         dsh;
	logic signed [16:0]         exc;
	logic [16:0]                slope_c;
	logic [15:0]                thr_s, env_s, cf;
	logic [31:0]                coef_s;
	logic signed [17:0]         dd;
	logic [16:0]                dmag;
	logic [15:0]                qq;
	logic [15:0]                ne;
	logic [SB+30:0]             yp;
	logic [SB:0]                ym;
	logic [AW-1:0]              pos_n;
	logic                       out_ld;

	assign xmag    = x_q[SB-1] ? (~x_q + 1'b1) : x_q;
	assign nsum    = sum_q - rpal_pkg::SUM_W'(rd_q) + rpal_pkg::SUM_W'(sq_q);
	assign sqv     = 62'(mx_q) * 62'(mx_q);
	assign lg      = $signed({10'd0, ln_q, fr_q});
	assign lv      = stg_q ? ((lg - $signed(rpal_pkg::PK_OFF)) <<< 1)
	                       : (lg - $signed(rpal_pkg::RMS_OFF));
	assign dsh     = 27'(p_q >>> 24);
	assign thr_s   = stg_q ? pthr_q : rthr_q;
	assign slope_c = (stg_q ? pslope_q : rslope_q) > rpal_pkg::SLOPE_ONE ?
	                 rpal_pkg::SLOPE_ONE : (stg_q ? pslope_q : rslope_q);
	assign coef_s  = stg_q ? pcoef_q : rcoef_q;
	assign env_s   = stg_q ? penv_q : renv_q;
	assign exc     = 17'(lvl_q) - 17'($signed(thr_s));
	assign cf      = (tgt_q > {1'b0, env_s}) ? coef_s[31:16] : coef_s[15:0];
	assign dd      = $signed({2'b00, env_s}) - $signed({1'b0, tgt_q});
	assign dmag    = dd[17] ? 17'(-dd) : 17'(dd);
	assign qq      = 16'((34'(dmag) * 34'(cf)) >> 16);
	assign ne      = dd[17] ? 16'(tgt_q - 17'(qq)) : 16'(tgt_q + 17'(qq));
	assign yp      = (SB+31)'(xmag) * (SB+31)'(g_q);
	assign ym      = yp[SB+30:30];
	assign pos_n   = (pos_q == AW'(rpal_pkg::WIN - 1)) ? '0 : pos_q + 1'b1;
	assign out_ld  = (st_q == rpal_pkg::ST_OUT) && (!ovld_q || pop);

	assign mem_we = (st_q == rpal_pkg::ST_CLR) || (st_q == rpal_pkg::ST_RSUM);
	assign mem_wa = (st_q == rpal_pkg::ST_CLR) ? clr_q : pos_q;
	assign mem_wd = (st_q == rpal_pkg::ST_CLR) ? '0 : sq_q;

	assign ack.take     = (st_q == rpal_pkg::ST_IDLE) && req.vld;
	assign ack.clr_done = (st_q != rpal_pkg::ST_CLR);

	assign empty              = !ovld_q;
	assign sample_out         = osmp_q;
	assign total_reduction_db = otot_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= '0;
			rthr_q   <= '0;
			pthr_q   <= '0;
			rslope_q <= rpal_pkg::SLOPE_RESET;
			pslope_q <= rpal_pkg::SLOPE_RESET;
			rcoef_q  <= '0;
			pcoef_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				rpal_pkg::REG_ENABLES:   en_q     <= wr_data[1:0];
				rpal_pkg::REG_RMS_THR:   rthr_q   <= wr_data[15:0];
				rpal_pkg::REG_RMS_SLOPE: rslope_q <= wr_data[16:0];
				rpal_pkg::REG_RMS_COEF:  rcoef_q  <= wr_data;
				rpal_pkg::REG_PK_THR:    pthr_q   <= wr_data[15:0];
				rpal_pkg::REG_PK_SLOPE:  pslope_q <= wr_data[16:0];
				rpal_pkg::REG_PK_COEF:   pcoef_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			rpal_pkg::ST_IDLE: begin
				x_q   <= req.sample;
				tot_q <= '0;
			end
			rpal_pkg::ST_RSQ: sq_q <= rpal_pkg::SQ_W'(xmag) * rpal_pkg::SQ_W'(xmag);
			rpal_pkg::ST_RSUM: begin
				lx_q  <= 64'(nsum);
				ln_q  <= 6'd63;
				lvl_q <= rpal_pkg::DB_FLOOR;
			end
			rpal_pkg::ST_NORM: begin
				if (lx_q[63]) begin
					mx_q <= lx_q[63:33];
					fr_q <= '0;
					it_q <= '0;
				end else if (lx_q[63:56] == 8'd0) begin
					lx_q <= lx_q << 8;
					ln_q <= ln_q - 6'd8;
				end else begin
					lx_q <= lx_q << 1;
					ln_q <= ln_q - 6'd1;
				end
			end
			rpal_pkg::ST_SQR: begin
				if (sqv[61]) begin
					mx_q <= sqv[61:31];
					fr_q <= {fr_q[14:0], 1'b1};
				end else begin
					mx_q <= sqv[60:30];
					fr_q <= {fr_q[14:0], 1'b0};
				end
				it_q <= it_q + 1'b1;
			end
			rpal_pkg::ST_LVL: p_q <= 51'(lv) * $signed({33'd0, rpal_pkg::DB_PER_LOG2});
			rpal_pkg::ST_DBS: begin
				if (dsh > 27'sd32767) lvl_q <= 16'sd32767;
				else if (dsh < -27'sd32768) lvl_q <= rpal_pkg::DB_FLOOR;
				else lvl_q <= 16'(dsh);
			end
			rpal_pkg::ST_ENVT: begin
				if (exc > 17'sd0) tgt_q <= 17'((34'(exc) * 34'(slope_c)) >> 16);
				else tgt_q <= '0;
			end
			rpal_pkg::ST_ENVE: begin
				e_q   <= ne;
				tot_q <= tot_q + 17'(ne);
			end
			rpal_pkg::ST_GT: begin
				t_q  <= 30'((38'(e_q) * 38'(rpal_pkg::LOG2_PER_DB)) >> 8);
				g_q  <= rpal_pkg::Q30_ONE;
				it_q <= '0;
			end
			rpal_pkg::ST_GEXP: begin
				if (t_q[4'd15 - it_q])
					g_q <= 31'((62'(g_q) * 62'(rpal_pkg::EXP_TAB[it_q])) >> 30);
				it_q <= it_q + 1'b1;
			end
			rpal_pkg::ST_GSH: begin
				if (t_q[29:16] >= 14'd31) g_q <= '0;
				else g_q <= g_q >> t_q[29:16];
			end
			rpal_pkg::ST_GMUL: begin
				if (x_q[SB-1]) x_q <= SB'(-$signed(ym));
				else if (ym > (SB+1)'((1 << (SB - 1)) - 1)) x_q <= SB'((1 << (SB - 1)) - 1);
				else x_q <= SB'(ym);
			end
			rpal_pkg::ST_PKS: begin
				lx_q  <= 64'(xmag);
				ln_q  <= 6'd63;
				lvl_q <= rpal_pkg::DB_FLOOR;
			end
			default: ;
		endcase
		if (out_ld) begin
			osmp_q <= x_q;
			otot_q <= tot_q[16] ? 16'hFFFF : tot_q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= rpal_pkg::ST_CLR;
			clr_q  <= '0;
			pos_q  <= '0;
			sum_q  <= '0;
			renv_q <= '0;
			penv_q <= '0;
			stg_q  <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (out_ld) ovld_q <= 1'b1;
			else if (pop && ovld_q) ovld_q <= 1'b0;
			case (st_q)
				rpal_pkg::ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(rpal_pkg::WIN - 1)) st_q <= rpal_pkg::ST_IDLE;
				end
				rpal_pkg::ST_IDLE: begin
					if (req.vld) begin
						stg_q <= 1'b0;
						if (en_q[0]) st_q <= rpal_pkg::ST_RSQ;
						else if (en_q[1]) st_q <= rpal_pkg::ST_PKS;
						else st_q <= rpal_pkg::ST_OUT;
					end
				end
				rpal_pkg::ST_RSQ: st_q <= rpal_pkg::ST_RSUM;
				rpal_pkg::ST_RSUM: begin
					sum_q <= nsum;
					pos_q <= pos_n;
					st_q  <= (nsum == '0) ? rpal_pkg::ST_ENVT : rpal_pkg::ST_NORM;
				end
				rpal_pkg::ST_NORM: if (lx_q[63]) st_q <= rpal_pkg::ST_SQR;
				rpal_pkg::ST_SQR: if (it_q == 4'd15) st_q <= rpal_pkg::ST_LVL;
				rpal_pkg::ST_LVL: st_q <= rpal_pkg::ST_DBS;
				rpal_pkg::ST_DBS: st_q <= rpal_pkg::ST_ENVT;
				rpal_pkg::ST_ENVT: st_q <= rpal_pkg::ST_ENVE;
				rpal_pkg::ST_ENVE: begin
					if (stg_q) penv_q <= ne;
					else renv_q <= ne;
					st_q <= rpal_pkg::ST_GT;
				end
				rpal_pkg::ST_GT: st_q <= rpal_pkg::ST_GEXP;
				rpal_pkg::ST_GEXP: if (it_q == 4'd15) st_q <= rpal_pkg::ST_GSH;
				rpal_pkg::ST_GSH: st_q <= rpal_pkg::ST_GMUL;
				rpal_pkg::ST_GMUL: begin
					if (!stg_q && en_q[1]) st_q <= rpal_pkg::ST_PKS;
					else st_q <= rpal_pkg::ST_OUT;
				end
				rpal_pkg::ST_PKS: begin
					stg_q <= 1'b1;
					st_q  <= (xmag == '0) ? rpal_pkg::ST_ENVT : rpal_pkg::ST_NORM;
				end
				rpal_pkg::ST_OUT: if (out_ld) st_q <= rpal_pkg::ST_IDLE;
				default: st_q <= rpal_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

### dv/tb.sv
// Testbench of the RMS and peak audio limiter: directed and random samples checked against a predictor.
`timescale 1ns / 1ps
module tb;
	import rpal_pkg::*;

	logic clk, arst_n, push, pop, wr_en;
	logic signed [SB-1:0] sample_in;
	logic full, empty;
	logic signed [SB-1:0] sample_out;
	logic [15:0] total_reduction_db;
	logic [CFG_IW-1:0] wr_index;
	logic [CFG_DW-1:0] wr_data;

	rms_and_peak_audio_limiter_unit dut (.*);

	typedef struct {
		logic [SB-1:0] smp;
		logic [15:0]   red;
	} lim_out_t;

	lim_out_t  want_q[$];
	int        errors;
	bit        pop_calm, push_calm;

	logic [1:0]  m_en;
	logic [15:0] m_rthr, m_pthr;
	logic [16:0] m_rslope, m_pslope;
	logic [31:0] m_rcoef, m_pcoef;
	logic [63:0] m_win[WIN];
	int          m_pos;
	logic [63:0] m_sum;
	logic [15:0] m_renv, m_penv;
	logic [63:0] m_etab[16];

	function automatic logic [63:0] sqrt64(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint lg2(logic [63:0] v);
		int n;
		logic [63:0] x;
		longint fr;
		n = 63;
		fr = 0;
		while (n > 0 && v[n] == 0) n--;
		x = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			fr = fr << 1;
			if (x >= 64'h8000_0000) begin
				x = x >> 1;
				fr = fr | 1;
			end
		end
		return (longint'(n) << 16) + fr;
	endfunction

	function automatic longint to_db(longint l);
		longint p, d;
		p = l * 197283;
		if (p >= 0) d = p >>> 24;
		else d = -((-p + 64'hFFFFFF) >>> 24);
		if (d > 32767) d = 32767;
		if (d < -32768) d = -32768;
		return d;
	endfunction

	function automatic logic [15:0] smooth(longint lvl, logic [15:0] thr, logic [16:0] sl,
			logic [31:0] cf, logic [15:0] env);
		longint t, d, q, s;
		logic [63:0] c, mag;
		s = (sl > 17'd65536) ? 65536 : sl;
		t = 0;
		if (lvl > longint'($signed(thr))) t = ((lvl - longint'($signed(thr))) * s) >>> 16;
		c = (t > longint'(env)) ? cf[31:16] : cf[15:0];
		d = longint'(env) - t;
		mag = d < 0 ? -d : d;
		q = (mag * c) >> 16;
		if (d < 0) q = -q;
		return 16'(t + q);
	endfunction

	function automatic longint gain(longint x, logic [15:0] env);
		logic [63:0] t, n, f, g, mag;
		longint y;
		t = (64'(env) * 2786640) >> 8;
		n = t >> 16;
		f = t & 16'hFFFF;
		g = 64'd1 << 30;
		for (int k = 0; k < 16; k++) if (f[15-k]) g = (g * m_etab[k]) >> 30;
		g = (n >= 31) ? 0 : (g >> n);
		mag = x < 0 ? -x : x;
		y = (mag * g) >> 30;
		if (x < 0) y = -y;
		if (y > 8388607) y = 8388607;
		if (y < -8388608) y = -8388608;
		return y;
	endfunction

	task automatic predict_limit(logic [SB-1:0] raw);
		longint x, lvl, tot;
		logic [63:0] mag, sq;
		lim_out_t r;
		x = longint'($signed(raw));
		tot = 0;
		if (m_en[0]) begin
			mag = x < 0 ? -x : x;
			sq = mag * mag;
			m_sum = m_sum - m_win[m_pos] + sq;
			m_win[m_pos] = sq;
			m_pos = (m_pos + 1) % WIN;
			lvl = (m_sum == 0) ? -32768 : to_db(lg2(m_sum) - lg2(WIN) - (longint'(46) << 16));
			m_renv = smooth(lvl, m_rthr, m_rslope, m_rcoef, m_renv);
			x = gain(x, m_renv);
			tot += m_renv;
		end
		if (m_en[1]) begin
			mag = x < 0 ? -x : x;
			lvl = (mag == 0) ? -32768 : to_db(2 * (lg2(mag) - (longint'(23) << 16)));
			m_penv = smooth(lvl, m_pthr, m_pslope, m_pcoef, m_penv);
			x = gain(x, m_penv);
			tot += m_penv;
		end
		if (tot > 65535) tot = 65535;
		r.smp = x[SB-1:0];
		r.red = tot[15:0];
		want_q.push_back(r);
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#300ms;
		$display("rms_and_peak_audio_limiter_unit regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result %h %h", $time, sample_out, total_reduction_db);
				errors++;
			end else begin
				if (want_q[0].smp !== sample_out || want_q[0].red !== total_reduction_db) begin
					$display("%0t: expected %h %h actual %h %h", $time, want_q[0].smp,
						want_q[0].red, sample_out, total_reduction_db);
					errors++;
				end
				void'(want_q.pop_front());
			end
		end
		pop <= pop_calm ? 1'b1 : ($urandom_range(99) >= 19);
	end

	task automatic send_sample(logic [SB-1:0] v);
		while (!push_calm && $urandom_range(99) < 19) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		sample_in <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_limit(v);
	endtask

	task automatic drain();
		push <= 0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] v);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 0;
		case (idx)
			REG_ENABLES:   m_en = v[1:0];
			REG_RMS_THR:   m_rthr = v[15:0];
			REG_RMS_SLOPE: m_rslope = v[16:0];
			REG_RMS_COEF:  m_rcoef = v;
			REG_PK_THR:    m_pthr = v[15:0];
			REG_PK_SLOPE:  m_pslope = v[16:0];
			REG_PK_COEF:   m_pcoef = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup(logic [1:0] en, logic [15:0] rt, logic [16:0] rs, logic [31:0] rc,
			logic [15:0] pt, logic [16:0] ps, logic [31:0] pc);
		drain();
		write_reg(REG_ENABLES, en);
		write_reg(REG_RMS_THR, rt);
		write_reg(REG_RMS_SLOPE, rs);
		write_reg(REG_RMS_COEF, rc);
		write_reg(REG_PK_THR, pt);
		write_reg(REG_PK_SLOPE, ps);
		write_reg(REG_PK_COEF, pc);
	endtask

	function automatic logic [SB-1:0] rand_sample();
		case ($urandom_range(5))
			0: return SB'($urandom_range(255));
			1: return -SB'($urandom_range(255));
			2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic test_bypass();
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(0);
		send_sample(24'hFFFFFF);
	endtask

	task automatic test_directed();
		setup(2'd3, 16'hF000, 17'd65536, 32'h1000_F000, 16'hFA00, 17'd90000, 32'h0000_8000);
		send_sample(0);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000001);
		send_sample(24'hFFFFFF);
		send_sample(24'h400000);
		send_sample(24'hC00000);
		drain();
		write_reg(3'd7, 32'hFFFF_FFFF);
		setup(2'd1, 16'h8000, 17'd0, 32'hFFFF_FFFF, 16'h7FFF, 17'h1FFFF, 32'hFFFF_FFFF);
		send_sample(24'h7FFFFF);
		send_sample(0);
		setup(2'd2, 16'h7FFF, 17'd1, 32'h0, 16'h8000, 17'd65536, 32'h0);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000003);
		send_sample(0);
		drain();
		push_calm = 1;
		for (int i = 0; i < 8; i++) send_sample(rand_sample());
		push_calm = 0;
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 13; ph++) begin
			setup(2'($urandom), 16'($urandom_range(0, 9000)) - 16'd8000,
				17'($urandom_range(0, 70000)), $urandom, 16'($urandom_range(0, 4000)) - 16'd3000,
				17'($urandom_range(0, 70000)), $urandom);
			pop_calm = (ph == 5);
			push_calm = (ph == 5);
			for (int i = 0; i < 50; i++) send_sample(rand_sample());
		end
		pop_calm = 0;
		push_calm = 0;
	endtask

	initial begin
		errors = 0;
		push = 0; pop = 0; wr_en = 0; wr_index = 0; wr_data = 0; sample_in = 0;
		pop_calm = 0; push_calm = 0;
		m_en = 0; m_rthr = 0; m_pthr = 0; m_rslope = SLOPE_RESET; m_pslope = SLOPE_RESET;
		m_rcoef = 0; m_pcoef = 0; m_pos = 0; m_sum = 0; m_renv = 0; m_penv = 0;
		for (int i = 0; i < WIN; i++) m_win[i] = 0;
		m_etab[0] = sqrt64(64'd1 << 59);
		for (int k = 1; k < 16; k++) m_etab[k] = sqrt64(m_etab[k-1] << 30);
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		test_bypass();
		test_directed();
		test_random();
		drain();
		if (errors == 0) $display("rms_and_peak_audio_limiter_unit regression: pass");
		else $display("rms_and_peak_audio_limiter_unit regression: fail");
		$finish;
	end
endmodule

### rms_and_peak_audio_limiter_unit.f
rtl/rpal_pkg.sv
rtl/rpal_front.sv
rtl/rpal_back.sv
rtl/rms_and_peak_audio_limiter_unit.sv
dv/tb.sv
